[rtl/ffca_pkg.sv]
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types, codes and default constants of the first-fit chunk allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

    // Defaults for the top-level parameters
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int MAX_CHUNKS_DEF   = 64;
    localparam int MAX_PAGES_DEF    = 16;

    // Fixed field widths
    localparam int OFS_W   = 16;  // offsets and byte counts
    localparam int SUM_W   = 17;  // offset plus header, merged sizes
    localparam int PAGES_W = 5;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNINIT = 2'd1,
        ST_OOM    = 2'd2,
        ST_BADARG = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_NX,
        S_FREE_NW,
        S_FREE_WR,
        S_ALLOC_DEC,
        S_SHIFT,
        S_WR_NEW,
        S_WR_CUR,
        S_RESP
    } state_t;

    // One row of the chunk table
    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] bytes;
        logic             is_free;
    } chunk_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic    cfg_load;
        logic    req_load;
        logic    scan_init;
        logic    scan_run;
        logic    next_rd;
        logic    next_cap;
        logic    merge_wr;
        logic    alloc_dec;
        logic    sh_run;
        logic    wr_new;
        logic    wr_cur;
        logic    res_set;
        logic    res_ofs;
        status_t res_code;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic null_req;
        logic uninit;
        logic is_free_op;
        logic hit;
        logic miss;
        logic split;
        logic sh_done;
    } flags_t;

endpackage

`default_nettype wire

[rtl/ffca_ram.sv]
// ----------------------------------------------------------------------------
// ffca_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]              wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/ffca_dpath.sv]
// ----------------------------------------------------------------------------
// ffca_dpath
// Datapath: chunk table RAM, scan, shift engine, merge/split arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_dpath #(
    parameter int PAGE_BYTES   = ffca_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = ffca_pkg::HEADER_BYTES_DEF,
    parameter int MAX_CHUNKS   = ffca_pkg::MAX_CHUNKS_DEF,
    parameter int MAX_PAGES    = ffca_pkg::MAX_PAGES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ffca_pkg::cmd_t              cmd,
    output ffca_pkg::flags_t                 flags,
    input  wire logic [ffca_pkg::PAGES_W-1:0] cfg_pages,
    input  wire logic                        mode,
    input  wire logic [ffca_pkg::OFS_W-1:0]  request_size,
    input  wire logic [ffca_pkg::OFS_W-1:0]  address,
    output logic      [ffca_pkg::OFS_W-1:0]  payload_offset,
    output logic      [1:0]                  status
);

    localparam int IDX_W = $clog2(MAX_CHUNKS > 1 ? MAX_CHUNKS : 2);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int OW    = ffca_pkg::OFS_W;
    localparam int SW    = ffca_pkg::SUM_W;
    localparam logic [SW-1:0]    HDR   = SW'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] CMAX  = CNT_W'(MAX_CHUNKS);
    localparam logic [ffca_pkg::PAGES_W-1:0] PMAX = ffca_pkg::PAGES_W'(MAX_PAGES);

    // Control and payload registers
    logic [ffca_pkg::PAGES_W-1:0] pages_reg;
    logic [CNT_W-1:0]             count_reg;
    logic                         mode_reg;
    logic [OW-1:0]                size_reg;
    logic [OW-1:0]                addr_reg;
    logic [CNT_W-1:0]             sc_idx_reg;
    logic                         sc_pend_reg;
    logic [IDX_W-1:0]             sc_didx_reg;
    ffca_pkg::chunk_entry_t       cur_reg, prev_reg, next_reg;
    logic [IDX_W-1:0]             cur_idx_reg;
    logic                         split_reg;
    logic [IDX_W-1:0]             sh_src_reg, sh_last_reg, sh_dst_reg, sh_r_reg;
    logic                         sh_up_reg, sh_issue_reg, sh_pend_reg;
    ffca_pkg::status_t            res_status_reg;
    logic [OW-1:0]                res_offset_reg;

    // RAM ports
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr, ram_raddr;
    ffca_pkg::chunk_entry_t       ram_wdata, ram_rdata;

    // Configuration: saturated page count and initial chunk
    logic [ffca_pkg::PAGES_W-1:0] pages_sat;
    logic [SW-1:0]                arena;
    ffca_pkg::chunk_entry_t       init_entry;

    assign pages_sat = (cfg_pages > PMAX) ? PMAX : cfg_pages;
    assign arena     = SW'(32'(pages_sat) * PAGE_BYTES);

    always_comb
    begin
        init_entry.start   = '0;
        init_entry.bytes   = (arena >= HDR) ? OW'(arena - HDR) : '0;
        init_entry.is_free = 1'b1;
    end

    // Scan match on the entry coming out of the RAM
    logic match;
    assign match = mode_reg ? (({1'b0, ram_rdata.start} + HDR) == {1'b0, addr_reg})
                            : (ram_rdata.is_free && (ram_rdata.bytes >= size_reg));

    // Neighbor and split decisions
    logic             need_next, pf, nf, split_now;
    logic [CNT_W-1:0] cur_p1, mrg_r, mrg_src0;
    logic [IDX_W-1:0] mrg_t;
    logic [OW-1:0]    rem;
    logic [SW-1:0]    mrg_bytes;
    ffca_pkg::chunk_entry_t mrg_entry, new_entry, cur_entry;

    assign cur_p1    = CNT_W'(cur_idx_reg) + CNT_W'(1);
    assign need_next = cur_p1 < count_reg;
    assign pf        = (cur_idx_reg != '0) && prev_reg.is_free;
    assign nf        = need_next && next_reg.is_free;
    assign mrg_r     = CNT_W'(pf) + CNT_W'(nf);
    assign mrg_t     = pf ? (cur_idx_reg - IDX_W'(1)) : cur_idx_reg;
    assign mrg_src0  = CNT_W'(mrg_t) + CNT_W'(1) + mrg_r;
    assign rem       = cur_reg.bytes - size_reg;
    assign split_now = ({1'b0, rem} >= HDR) && (count_reg < CMAX);
    assign mrg_bytes = (pf ? ({1'b0, prev_reg.bytes} + HDR) : '0)
                     + {1'b0, cur_reg.bytes}
                     + (nf ? ({1'b0, next_reg.bytes} + HDR) : '0);

    always_comb
    begin
        mrg_entry.start   = pf ? prev_reg.start : cur_reg.start;
        mrg_entry.bytes   = OW'(mrg_bytes);
        mrg_entry.is_free = 1'b1;
        new_entry.start   = OW'({1'b0, cur_reg.start} + HDR + {1'b0, size_reg});
        new_entry.bytes   = OW'({1'b0, rem} - HDR);
        new_entry.is_free = 1'b1;
        cur_entry.start   = cur_reg.start;
        cur_entry.bytes   = split_reg ? size_reg : cur_reg.bytes;
        cur_entry.is_free = 1'b0;
    end

    // RAM write port select
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = init_entry;
        if (cmd.cfg_load)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.merge_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = mrg_t;
            ram_wdata = mrg_entry;
        end
        else if (cmd.sh_run && sh_pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = sh_dst_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.wr_new)
        begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(cur_p1);
            ram_wdata = new_entry;
        end
        else if (cmd.wr_cur)
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_idx_reg;
            ram_wdata = cur_entry;
        end
    end

    // RAM read port select
    always_comb
    begin
        ram_raddr = '0;
        if (cmd.scan_run)
        begin
            ram_raddr = sc_idx_reg[IDX_W-1:0];
        end
        else if (cmd.next_rd)
        begin
            ram_raddr = IDX_W'(cur_p1);
        end
        else if (cmd.sh_run)
        begin
            ram_raddr = sh_src_reg;
        end
    end

    ffca_ram #(
        .WIDTH ($bits(ffca_pkg::chunk_entry_t)),
        .DEPTH (MAX_CHUNKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers: page count, chunk count, scan and shift sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg    <= '0;
            count_reg    <= CNT_W'(1);
            sc_idx_reg   <= '0;
            sc_pend_reg  <= 1'b0;
            sh_issue_reg <= 1'b0;
            sh_pend_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_load)
            begin
                pages_reg <= pages_sat;
                count_reg <= CNT_W'(1);
            end
            else if (cmd.merge_wr)
            begin
                count_reg <= count_reg - mrg_r;
            end
            else if (cmd.wr_new)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            // Table scan, one read issued per cycle
            if (cmd.scan_init)
            begin
                sc_idx_reg  <= '0;
                sc_pend_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                if (sc_idx_reg < count_reg)
                begin
                    sc_pend_reg <= 1'b1;
                    sc_idx_reg  <= sc_idx_reg + CNT_W'(1);
                end
                else
                begin
                    sc_pend_reg <= 1'b0;
                end
            end

            // Shift engine setup and run
            if (cmd.merge_wr)
            begin
                sh_issue_reg <= (mrg_r != '0) && (mrg_src0 < count_reg);
                sh_pend_reg  <= 1'b0;
            end
            else if (cmd.alloc_dec)
            begin
                sh_issue_reg <= split_now && need_next;
                sh_pend_reg  <= 1'b0;
            end
            else if (cmd.sh_run)
            begin
                sh_pend_reg <= sh_issue_reg;
                if (sh_issue_reg && (sh_src_reg == sh_last_reg))
                begin
                    sh_issue_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            mode_reg <= mode;
            size_reg <= request_size;
            addr_reg <= address;
        end

        if (cmd.scan_run)
        begin
            sc_didx_reg <= sc_idx_reg[IDX_W-1:0];
            if (sc_pend_reg)
            begin
                if (match)
                begin
                    cur_reg     <= ram_rdata;
                    cur_idx_reg <= sc_didx_reg;
                end
                else
                begin
                    prev_reg <= ram_rdata;
                end
            end
        end

        if (cmd.next_cap)
        begin
            next_reg <= ram_rdata;
        end

        if (cmd.merge_wr)
        begin
            sh_up_reg   <= 1'b0;
            sh_src_reg  <= IDX_W'(mrg_src0);
            sh_last_reg <= IDX_W'(count_reg - CNT_W'(1));
            sh_r_reg    <= IDX_W'(mrg_r);
        end
        else if (cmd.alloc_dec)
        begin
            split_reg   <= split_now;
            sh_up_reg   <= 1'b1;
            sh_src_reg  <= IDX_W'(count_reg - CNT_W'(1));
            sh_last_reg <= IDX_W'(cur_p1);
            sh_r_reg    <= IDX_W'(1);
        end
        else if (cmd.sh_run && sh_issue_reg)
        begin
            sh_dst_reg <= sh_up_reg ? (sh_src_reg + sh_r_reg) : (sh_src_reg - sh_r_reg);
            sh_src_reg <= sh_up_reg ? (sh_src_reg - IDX_W'(1)) : (sh_src_reg + IDX_W'(1));
        end

        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
            res_offset_reg <= cmd.res_ofs ? OW'({1'b0, cur_reg.start} + HDR) : '0;
        end
    end

    // Status toward the controller
    always_comb
    begin
        flags.null_req   = mode && (address == '0);
        flags.uninit     = (pages_reg == '0);
        flags.is_free_op = mode_reg;
        flags.hit        = sc_pend_reg && match;
        flags.miss       = !sc_pend_reg && (sc_idx_reg >= count_reg);
        flags.split      = split_now;
        flags.sh_done    = !sh_issue_reg && !sh_pend_reg;
    end

    assign payload_offset = res_offset_reg;
    assign status         = res_status_reg;

    // Table never empty and never beyond capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CMAX))
        else $error("chunk count out of range");

    // A split only happens with a free table slot
    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_new |-> (count_reg < CMAX))
        else $error("split into full table");

    // Shift never writes the row it is reading
    a_shift_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sh_run && sh_pend_reg && sh_issue_reg) |-> (sh_dst_reg != sh_src_reg))
        else $error("shift read/write collision");

endmodule

`default_nettype wire

[rtl/ffca_ctrl.sv]
// ----------------------------------------------------------------------------
// ffca_ctrl
// Controller: sequences scan, merge, split and shift for each request.
// ----------------------------------------------------------------------------
`default_nettype none

module ffca_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              cfg_valid,
    input  wire ffca_pkg::flags_t  flags,
    output ffca_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done,
    output logic                   cfg_ready
);

    ffca_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffca_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffca_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (flags.null_req || flags.uninit)
                    begin
                        state_next = ffca_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = ffca_pkg::S_SCAN;
                    end
                end
            end
            ffca_pkg::S_SCAN:
            begin
                if (flags.hit)
                begin
                    state_next = flags.is_free_op ? ffca_pkg::S_FREE_NX : ffca_pkg::S_ALLOC_DEC;
                end
                else if (flags.miss)
                begin
                    state_next = ffca_pkg::S_RESP;
                end
            end
            ffca_pkg::S_FREE_NX:   state_next = ffca_pkg::S_FREE_NW;
            ffca_pkg::S_FREE_NW:   state_next = ffca_pkg::S_FREE_WR;
            ffca_pkg::S_FREE_WR:   state_next = ffca_pkg::S_SHIFT;
            ffca_pkg::S_ALLOC_DEC:
            begin
                state_next = flags.split ? ffca_pkg::S_SHIFT : ffca_pkg::S_WR_CUR;
            end
            ffca_pkg::S_SHIFT:
            begin
                if (flags.sh_done)
                begin
                    state_next = flags.is_free_op ? ffca_pkg::S_RESP : ffca_pkg::S_WR_NEW;
                end
            end
            ffca_pkg::S_WR_NEW:    state_next = ffca_pkg::S_WR_CUR;
            ffca_pkg::S_WR_CUR:    state_next = ffca_pkg::S_RESP;
            ffca_pkg::S_RESP:      state_next = ffca_pkg::S_IDLE;
            default:               state_next = ffca_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ffca_pkg::S_IDLE:
            begin
                cmd.cfg_load = cfg_valid;
                if (start)
                begin
                    cmd.req_load  = 1'b1;
                    cmd.scan_init = 1'b1;
                    if (flags.null_req)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = ffca_pkg::ST_OK;
                    end
                    else if (flags.uninit)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = ffca_pkg::ST_UNINIT;
                    end
                end
            end
            ffca_pkg::S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (!flags.hit && flags.miss)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = flags.is_free_op ? ffca_pkg::ST_BADARG : ffca_pkg::ST_OOM;
                end
            end
            ffca_pkg::S_FREE_NX:   cmd.next_rd  = 1'b1;
            ffca_pkg::S_FREE_NW:   cmd.next_cap = 1'b1;
            ffca_pkg::S_FREE_WR:
            begin
                cmd.merge_wr = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_code = ffca_pkg::ST_OK;
            end
            ffca_pkg::S_ALLOC_DEC:
            begin
                cmd.alloc_dec = 1'b1;
                cmd.res_set   = 1'b1;
                cmd.res_ofs   = 1'b1;
                cmd.res_code  = ffca_pkg::ST_OK;
            end
            ffca_pkg::S_SHIFT:     cmd.sh_run = 1'b1;
            ffca_pkg::S_WR_NEW:    cmd.wr_new = 1'b1;
            ffca_pkg::S_WR_CUR:    cmd.wr_cur = 1'b1;
            default:               cmd = '0;
        endcase
    end

    assign busy      = (state_reg != ffca_pkg::S_IDLE);
    assign cfg_ready = (state_reg == ffca_pkg::S_IDLE);
    assign done      = (state_reg == ffca_pkg::S_RESP);

    // Result strobe lasts one cycle and frees the block
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // An accepted request always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // A failed scan answers in the next cycle
    a_miss_resp: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ffca_pkg::S_SCAN) && !flags.hit && flags.miss) |=> done)
        else $error("scan miss without result");

endmodule

`default_nettype wire

[rtl/first_fit_chunk_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator_core
// First-fit chunk allocator with coalescing over an address-ordered table.
// ----------------------------------------------------------------------------
//  Channel   Signals                                      Transaction when
//  request   start, busy, mode, request_size, address     start && !busy
//  result    done, payload_offset, status                 done (one cycle)
//  config    cfg_valid, cfg_ready, arena_pages            cfg_valid && cfg_ready
//
//  Sequence: null or uninitialized requests go straight to the result. Otherwise
//  the table scan reads the rows up to the match, then the row shift for a split
//  or merge moves one row per cycle through the single table RAM port pair.
//  Reset: arena is uninitialized; no clearing pass, a config write loads row 0.
//  The result cannot be stalled; busy stays high until the strobe cycle ends.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_chunk_allocator_core #(
    parameter int PAGE_BYTES   = ffca_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = ffca_pkg::HEADER_BYTES_DEF,
    parameter int MAX_CHUNKS   = ffca_pkg::MAX_CHUNKS_DEF,
    parameter int MAX_PAGES    = ffca_pkg::MAX_PAGES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         mode,
    input  wire logic [ffca_pkg::OFS_W-1:0]   request_size,
    input  wire logic [ffca_pkg::OFS_W-1:0]   address,
    output logic                              done,
    output logic      [ffca_pkg::OFS_W-1:0]   payload_offset,
    output logic      [1:0]                   status,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ffca_pkg::PAGES_W-1:0] arena_pages
);

    ffca_pkg::cmd_t   cmd;
    ffca_pkg::flags_t flags;

    ffca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .flags     (flags),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .cfg_ready (cfg_ready)
    );

    ffca_dpath #(
        .PAGE_BYTES   (PAGE_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_CHUNKS   (MAX_CHUNKS),
        .MAX_PAGES    (MAX_PAGES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .flags          (flags),
        .cfg_pages      (arena_pages),
        .mode           (mode),
        .request_size   (request_size),
        .address        (address),
        .payload_offset (payload_offset),
        .status         (status)
    );

endmodule

`default_nettype wire
